FILE: rtl/core/sma_pkg.sv
// shared constants and types for the simple moving average block
package sma_pkg;

    // window and sample sizes
    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_WIDTH = 32;
    localparam int PTR_W        = $clog2(MAX_WINDOW);
    localparam int WIN_W        = PTR_W + 1;
    localparam int SUM_W        = SAMPLE_WIDTH + PTR_W;

    // divider sizing: one quotient bit per cycle
    localparam int DIV_STEPS    = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // window length after reset
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(20);

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: rtl/core/sma_divider.sv
// iterative restoring divider, window sum over window length, one bit per cycle
module sma_divider (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [sma_pkg::SUM_W-1:0]       dividend,
    input  logic [sma_pkg::WIN_W-1:0]       divisor,
    output sma_pkg::div_status_t            status,
    output logic [sma_pkg::SUM_W-1:0]       quotient
);

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    div_state_t                      state_reg;
    logic [sma_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [sma_pkg::SUM_W-1:0]       quo_reg;
    logic [sma_pkg::WIN_W-1:0]       rem_reg;
    logic [sma_pkg::WIN_W-1:0]       div_reg;

    logic [sma_pkg::WIN_W:0]         trial;
    logic [sma_pkg::WIN_W:0]         diff;
    logic                            fits;

    // one restoring step: shift in next dividend bit, try to subtract
    always_comb begin
        trial = {rem_reg, quo_reg[sma_pkg::SUM_W-1]};
        fits  = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};
    end

    // state, counter and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                DIV_IDLE: begin
                    if (start) begin
                        state_reg <= DIV_RUN;
                        cnt_reg   <= sma_pkg::DIV_CNT_W'(sma_pkg::DIV_STEPS - 1);
                        quo_reg   <= dividend;
                        rem_reg   <= '0;
                        div_reg   <= divisor;
                    end
                end
                DIV_RUN: begin
                    quo_reg <= {quo_reg[sma_pkg::SUM_W-2:0], fits};
                    rem_reg <= fits ? diff[sma_pkg::WIN_W-1:0] : trial[sma_pkg::WIN_W-1:0];
                    if (cnt_reg == '0) begin
                        state_reg <= DIV_DONE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                DIV_DONE: begin
                    state_reg <= DIV_IDLE;
                end
                default: begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != DIV_IDLE);
    assign status.done = (state_reg == DIV_DONE);
    assign quotient    = quo_reg;

endmodule

FILE: rtl/core/simple_moving_average_top.sv
// simple moving average over unsigned Q16.16 price samples, top level
//
// Channels: s_ carries one price sample per beat, m_ carries one average per
// beat, cfg_ writes the window length (1..256; zero acts as 1, larger values
// as 256). A window length write clears the running sum, the fill count and
// the ring pointer, so the next window fills from empty; the ring keeps its
// contents. cfg_ready is always high; write only while no sample is in work.
// No average is sent until the window holds window_length samples; from then
// on every sample yields one average, the window sum divided by the length,
// truncated.
// Sequence: acceptance starts a registered ring read, ST_READ waits for it,
// ST_UPDATE updates the sum and writes the sample back, then in ST_DIV the
// serial divider produces one quotient bit per cycle, and ST_OUT loads the
// average into the output register. A new sample is taken only after that,
// or after ST_UPDATE for a sample that yields no average.
// A finished average waits in the output register while m_tready is low; the
// next sample is still accepted and processed, and its result waits in the
// divider until the output register drains.
// Reset (aresetn low, synchronous) clears the window length to 20 and empties
// the window and output register; ring contents are left as they are.
module simple_moving_average_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // [31:0] price_sample
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [31:0]                        m_tdata,   // [31:0] average_value
    // window length writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [8:0]                         cfg_wdata  // [8:0] window_length
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_OUT
    } state_t;

    localparam int PTR_W = sma_pkg::PTR_W;
    localparam int WIN_W = sma_pkg::WIN_W;
    localparam int SUM_W = sma_pkg::SUM_W;
    localparam int SW    = sma_pkg::SAMPLE_WIDTH;

    state_t                 state_reg,   state_next;
    logic [SW-1:0]          sample_reg,  sample_next;
    logic [SUM_W-1:0]       sum_reg,     sum_next;
    logic [WIN_W-1:0]       seen_reg,    seen_next;
    logic [PTR_W-1:0]       ptr_reg,     ptr_next;
    logic [PTR_W-1:0]       pos_reg,     pos_next;
    logic [WIN_W-1:0]       win_reg,     win_next;
    logic [SW-1:0]          out_data_reg, out_data_next;
    logic                   out_valid_reg, out_valid_next;

    // ring memory
    logic [SW-1:0]          ring_mem [sma_pkg::MAX_WINDOW];
    logic [SW-1:0]          ring_rdata_reg;
    logic                   ring_re;
    logic                   ring_we;

    logic [WIN_W-1:0]       eff_len;
    logic [PTR_W-1:0]       pos_start;
    logic [WIN_W-1:0]       pos_inc;
    logic [WIN_W-1:0]       seen_inc;
    logic                   window_full;
    logic [SUM_W-1:0]       sum_update;
    logic                   div_start;
    sma_pkg::div_status_t   div_status;
    logic [SUM_W-1:0]       div_quotient;

    // effective window length: zero acts as one, saturate at ring depth
    always_comb begin
        if (win_reg == '0) begin
            eff_len = WIN_W'(1);
        end else if (win_reg > WIN_W'(sma_pkg::MAX_WINDOW)) begin
            eff_len = WIN_W'(sma_pkg::MAX_WINDOW);
        end else begin
            eff_len = win_reg;
        end
    end

    // ring slot for the incoming sample and the update arithmetic
    always_comb begin
        pos_start   = ({1'b0, ptr_reg} >= eff_len) ? '0 : ptr_reg;
        window_full = (seen_reg >= eff_len);
        sum_update  = sum_reg + SUM_W'(sample_reg)
                      - (window_full ? SUM_W'(ring_rdata_reg) : '0);
        pos_inc     = {1'b0, pos_reg} + 1'b1;
        seen_inc    = (seen_reg < eff_len) ? seen_reg + 1'b1 : seen_reg;
    end

    // sequencer next state
    always_comb begin
        state_next     = state_reg;
        sample_next    = sample_reg;
        sum_next       = sum_reg;
        seen_next      = seen_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        win_next       = win_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        ring_re        = 1'b0;
        ring_we        = 1'b0;
        div_start      = 1'b0;

        // output register drains on a result beat
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata;
                    pos_next    = pos_start;
                    ring_re     = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                ring_we   = 1'b1;
                sum_next  = sum_update;
                seen_next = seen_inc;
                ptr_next  = (pos_inc >= eff_len) ? '0 : pos_inc[PTR_W-1:0];
                if (seen_inc >= eff_len) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = div_quotient[SW-1:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // window length write restarts the window
        if (cfg_valid) begin
            win_next  = cfg_wdata;
            sum_next  = '0;
            seen_next = '0;
            ptr_next  = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            seen_reg      <= '0;
            ptr_reg       <= '0;
            win_reg       <= sma_pkg::WINDOW_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            ptr_reg       <= ptr_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
        sample_reg   <= sample_next;
        pos_reg      <= pos_next;
        out_data_reg <= out_data_next;
    end

    // ring memory: registered read at accept, write back on update
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[pos_reg] <= sample_reg;
        end
        if (ring_re) begin
            ring_rdata_reg <= ring_mem[pos_start];
        end
    end

    // serial divider for the average
    sma_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_update),
        .divisor  (eff_len),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

endmodule

FILE: rtl/core/sma_checker.sv
// port-level checks for the simple moving average top, with bind
module sma_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata
);

    // a stalled result beat stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // an accepted sample holds off input for the ring read and update
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input accepted during ring read or update");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat offered right after reset");

endmodule

bind simple_moving_average_top sma_checker u_sma_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: tb/simple_moving_average_top_test.sv
// testbench for the simple moving average block: random windows, prices and flow control
`timescale 1ns / 100ps

module simple_moving_average_top_test;

    localparam int HALF_PERIOD    = 6;
    localparam int SETTLE_CYCLES  = 60;
    localparam int LONG_HOLD      = 700;
    localparam int RANDOM_BEATS   = 900;
    localparam longint RUN_LIMIT  = 64'd11_000_000;

    typedef enum int {PRICE_ANY, PRICE_FULL, PRICE_LOW, PRICE_MIX} price_kind_t;
    typedef enum int {RX_FREE, RX_COIN, RX_SLOW, RX_BURSTY} rx_mode_t;

    typedef struct {
        logic [31:0] price;
        bit          wait_drain;
    } price_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;       // [31:0] price_sample
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // [31:0] average_value
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_wdata = '0;     // [8:0] window_length

    simple_moving_average_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // prices waiting to be sent and averages waiting to arrive
    price_beat_t price_queue[$];
    logic [31:0] expected_averages[$];
    int          mismatches = 0;
    bit          s_took = 1'b0;

    // append a price to the send queue
    task automatic queue_beat(input price_beat_t beat);
        price_queue.insert(price_queue.size(), beat);
    endtask

    // append an average to the expected queue
    task automatic queue_average(input logic [31:0] avg);
        expected_averages.insert(expected_averages.size(), avg);
    endtask

    // window state mirrored from the block
    logic [8:0]  window_len_reg = sma_pkg::WINDOW_RESET;
    logic [31:0] price_history [0:sma_pkg::MAX_WINDOW-1];
    logic [63:0] window_sum = '0;
    int unsigned fill_count = 0;
    int unsigned ring_slot = 0;

    // averaging span that a register value stands for
    function automatic int unsigned span_of(input logic [8:0] reg_val);
        if (reg_val == 0)
            return 1;
        if (reg_val > sma_pkg::MAX_WINDOW)
            return sma_pkg::MAX_WINDOW;
        return reg_val;
    endfunction

    // push one price into the window and queue the average it yields
    task automatic advance_window(input logic [31:0] price);
        int unsigned span;
        int unsigned slot;
        span = span_of(window_len_reg);
        slot = (ring_slot >= span) ? 0 : ring_slot;
        window_sum += 64'(price);
        if (fill_count >= span)
            window_sum -= 64'(price_history[slot]);
        price_history[slot] = price;
        slot++;
        if (slot >= span)
            slot = 0;
        ring_slot = slot;
        if (fill_count < span)
            fill_count++;
        if (fill_count >= span)
            queue_average(32'(window_sum / 64'(span)));
    endtask

    // sender: bursts of random length with random gaps, optional drain pause
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin
        price_beat_t beat;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (price_queue.size() != 0 &&
                         !(price_queue[0].wait_drain && expected_averages.size() != 0)) begin
                beat = price_queue.pop_front();
                s_tdata  <= beat.price;
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern in changing modes, plus one long hold-off on request
    bit          hold_ask = 1'b0;
    bit          hold_started = 1'b0;
    int          stall_left = 0;
    int          mode_left = 0;
    rx_mode_t    rx_mode = RX_FREE;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_ask && !hold_started) begin
            hold_started = 1'b1;
            stall_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE: m_tready <= 1'b1;
                RX_COIN: m_tready <= 1'($urandom_range(0, 1));
                RX_SLOW: m_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left = $urandom_range(1, 80);
                end
            endcase
        end
    end

    // monitor: track config and input beats, check output beats
    always @(posedge aclk) begin
        logic [31:0] want;
        if (!aresetn) begin
            s_took = 1'b0;
        end else begin
            s_took = s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                window_len_reg = cfg_wdata;
                window_sum = '0;
                fill_count = 0;
                ring_slot = 0;
            end
            if (s_took)
                advance_window(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_averages.size() == 0) begin
                    mismatches++;
                    $display("%0t: average %08h arrived with none expected", $time, m_tdata);
                end else begin
                    want = expected_averages.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        $display("%0t: average_value mismatch, expected %08h, got %08h",
                                 $time, want, m_tdata);
                    end
                end
            end
        end
    end

    function automatic logic [31:0] pick_price(input price_kind_t kind);
        case (kind)
            PRICE_FULL: return 32'hFFFF_FFFF;
            PRICE_LOW:  return $urandom_range(0, 32'h0003_FFFF);
            PRICE_MIX: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return {16'($urandom_range(50, 900)), 16'($urandom)};
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_prices(input int count, input price_kind_t kind, input int drain_at);
        price_beat_t beat;
        for (int i = 0; i < count; i++) begin
            beat.price = pick_price(kind);
            beat.wait_drain = (i == drain_at) || ($urandom_range(0, 39) == 0);
            queue_beat(beat);
        end
    endtask

    // wait until nothing is pending or in flight, then let the block go quiet
    task automatic settle();
        do @(posedge aclk);
        while (price_queue.size() != 0 || s_tvalid || expected_averages.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_window(input logic [8:0] wlen);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= wlen;
        do @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin
        logic [31:0] opening [0:20];
        price_beat_t beat;
        logic [8:0]  wlen;
        int          random_beats;
        int          pick;
        int unsigned span;
        int          count;

        opening = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'h0001_0000, 32'h0000_FFFF, 32'hFFFF_0000, 32'h8000_0000,
                    32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h0064_8000, 32'h00C8_4000, 32'h0000_0000, 32'hFFFF_FFFE,
                    32'h1234_5678, 32'h0FF0_F00F, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'h0101_0101};

        // reset
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset window of 20, filling and one step past full
        foreach (opening[i]) begin
            beat.price = opening[i];
            beat.wait_drain = 1'b0;
            queue_beat(beat);
        end
        // window of one passes prices straight through
        write_window(9'd1);
        queue_prices(1, PRICE_FULL, -1);
        beat.price = 32'h0000_0000;
        beat.wait_drain = 1'b0;
        queue_beat(beat);
        // zero length acts as a window of one
        write_window(9'd0);
        queue_prices(1, PRICE_FULL, -1);
        beat.price = 32'h0000_0001;
        queue_beat(beat);

        // full window of full-scale prices, then the largest register value
        random_beats = 0;
        write_window(9'd256);
        queue_prices(sma_pkg::MAX_WINDOW + 12, PRICE_FULL, -1);
        random_beats += sma_pkg::MAX_WINDOW + 12;
        write_window(9'd511);
        queue_prices(sma_pkg::MAX_WINDOW + 8, PRICE_ANY, 100);
        random_beats += sma_pkg::MAX_WINDOW + 8;

        // long receiver hold-off while the sender keeps offering
        write_window(9'd2);
        @(posedge aclk);
        hold_ask = 1'b1;
        queue_prices(40, PRICE_MIX, 20);
        random_beats += 40;

        // random windows, some cut short by the next window write
        while (random_beats < RANDOM_BEATS) begin
            pick = $urandom_range(0, 19);
            if (pick < 4)
                wlen = 9'($urandom_range(0, 3));
            else if (pick < 12)
                wlen = 9'($urandom_range(4, 16));
            else if (pick < 19)
                wlen = 9'($urandom_range(17, 64));
            else
                wlen = 9'($urandom_range(200, 511));
            span = span_of(wlen);
            if ($urandom_range(0, 7) == 0)
                count = $urandom_range(0, span - 1);
            else
                count = span + $urandom_range(0, 30);
            write_window(wlen);
            queue_prices(count, price_kind_t'($urandom_range(0, 3)), -1);
            random_beats += count;
        end

        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: simple_moving_average_top.f
rtl/core/sma_pkg.sv
rtl/core/sma_divider.sv
rtl/core/simple_moving_average_top.sv
rtl/core/sma_checker.sv
tb/simple_moving_average_top_test.sv
